>>> design/c_esc_pkg.sv
package c_esc_pkg;

  // Characters with a meaning to the decoder
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_X         = 8'h78;

  // One decoded byte as it leaves the block
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [15:0] length;
  } res_t;

  // What the decode core hands to the output queue for one accepted item
  typedef struct packed {
    logic [1:0] nres;   // 0, 1 or 2 results
    res_t       res0;
    res_t       res1;
  } core_out_t;

endpackage

>>> design/c_esc_core.sv
module c_esc_core #(
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_fire,
  input  logic [7:0]            in_char,
  input  logic                  in_last,
  output c_esc_pkg::core_out_t  core_out
);
  import c_esc_pkg::*;

  localparam int LEN_W = COUNT_BITS + 16;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(65535);

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_HEX1   = 3'd2,
    MODE_HEX2   = 3'd3,
    MODE_OCT1   = 3'd4,
    MODE_OCT2   = 3'd5
  } mode_t;

  mode_t                 mode_r, mode_nxt;
  logic [7:0]            part_r, part_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;

  mode_t                 mode_mid;
  logic [7:0]            part_mid;
  logic [3:0]            dv;
  logic [1:0]            n;
  logic [7:0]            b0, b1;
  logic [COUNT_BITS-1:0] cnt1, cnt2;

  // hex digit value, anything else is zero
  function automatic logic [3:0] digit_val(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= "0" && c <= "9") v = 4'(c - "0");
    else if (c >= "a" && c <= "f") v = 4'(c - "a" + 8'd10);
    else if (c >= "A" && c <= "F") v = 4'(c - "A" + 8'd10);
    return v;
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    logic [COUNT_BITS-1:0] r;
    r = v;
    if (v != '1) r = v + 1'b1;
    return r;
  endfunction

  function automatic logic [15:0] len_of(input logic [COUNT_BITS-1:0] v);
    logic [LEN_W-1:0] w;
    w = {16'd0, v};
    if (w > LEN_MAX) w = LEN_MAX;
    return w[15:0];
  endfunction

  assign dv   = digit_val(in_char);
  assign cnt1 = sat_inc(cnt_r);
  assign cnt2 = sat_inc(cnt1);

  always_comb begin
    mode_mid = mode_r;
    part_mid = part_r;
    n        = 2'd0;
    b0       = 8'h00;
    b1       = 8'h00;
    unique case (mode_r)
      MODE_ESC: begin
        mode_mid = MODE_NORMAL;
        unique case (in_char)
          "n":          begin n = 2'd1; b0 = 8'h0A; end
          "t":          begin n = 2'd1; b0 = 8'h09; end
          "a":          begin n = 2'd1; b0 = 8'h07; end
          "b":          begin n = 2'd1; b0 = 8'h08; end
          "f":          begin n = 2'd1; b0 = 8'h0C; end
          "r":          begin n = 2'd1; b0 = 8'h0D; end
          "v":          begin n = 2'd1; b0 = 8'h0B; end
          CH_BACKSLASH: begin n = 2'd1; b0 = CH_BACKSLASH; end
          CH_DQUOTE:    begin n = 2'd1; b0 = CH_DQUOTE; end
          CH_X: begin
            part_mid = 8'h00;
            mode_mid = MODE_HEX1;
          end
          default: begin
            priority if (in_char >= "0" && in_char <= "9") begin
              part_mid = in_char - "0";
              mode_mid = MODE_OCT1;
            end else begin
              // unknown escape: backslash, then the character
              n  = 2'd2;
              b0 = CH_BACKSLASH;
              b1 = in_char;
            end
          end
        endcase
      end
      MODE_HEX1: begin
        part_mid = {dv, 4'h0};
        mode_mid = MODE_HEX2;
      end
      MODE_HEX2: begin
        n        = 2'd1;
        b0       = part_r + {4'h0, dv};
        mode_mid = MODE_NORMAL;
      end
      MODE_OCT1: begin
        part_mid = {part_r[4:0], 3'b000} + {4'h0, dv};
        mode_mid = MODE_OCT2;
      end
      MODE_OCT2: begin
        n        = 2'd1;
        b0       = {part_r[4:0], 3'b000} + {4'h0, dv};
        mode_mid = MODE_NORMAL;
      end
      default: begin
        if (in_char == CH_BACKSLASH) begin
          mode_mid = MODE_ESC;
        end else begin
          n  = 2'd1;
          b0 = in_char;
        end
      end
    endcase

    // end of string flushes a pending escape; missing digits are zero
    if (in_last && mode_mid != MODE_NORMAL) begin
      n  = 2'd1;
      unique case (mode_mid)
        MODE_ESC:  b0 = CH_BACKSLASH;
        MODE_HEX1: b0 = 8'h00;
        MODE_HEX2: b0 = part_mid;
        MODE_OCT1: b0 = {part_mid[1:0], 6'd0};
        MODE_OCT2: b0 = {part_mid[4:0], 3'd0};
        default:   b0 = 8'h00;
      endcase
    end
  end

  always_comb begin
    core_out.nres        = n;
    core_out.res0.data   = b0;
    core_out.res0.last   = in_last && (n == 2'd1);
    core_out.res0.length = len_of(cnt1);
    core_out.res1.data   = b1;
    core_out.res1.last   = in_last;
    core_out.res1.length = len_of(cnt2);
  end

  always_comb begin
    mode_nxt = mode_r;
    part_nxt = part_r;
    cnt_nxt  = cnt_r;
    if (in_fire) begin
      if (in_last) begin
        mode_nxt = MODE_NORMAL;
        part_nxt = 8'h00;
        cnt_nxt  = '0;
      end else begin
        mode_nxt = mode_mid;
        part_nxt = part_mid;
        unique case (n)
          2'd1:    cnt_nxt = cnt1;
          2'd2:    cnt_nxt = cnt2;
          default: cnt_nxt = cnt_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      part_r <= 8'h00;
      cnt_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      part_r <= part_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // two results only come from an unknown escape
  a_two_from_esc: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && n == 2'd2 |-> mode_r == MODE_ESC)
    else $error("two results outside escape mode");

  // a finished string leaves the decoder clean
  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_last |=> mode_r == MODE_NORMAL && part_r == 8'h00 && cnt_r == '0)
    else $error("state not cleared after end of string");

  // the final item of a string always yields a byte
  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_last |-> n != 2'd0)
    else $error("end of string without a result");

endmodule

>>> design/c_esc_outq.sv
module c_esc_outq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_fire,
  input  c_esc_pkg::core_out_t  core_out,
  output logic                  space_ok,
  output logic                  out_valid,
  input  logic                  out_ready,
  output c_esc_pkg::res_t       out_res
);
  import c_esc_pkg::*;

  localparam int DEPTH = 3;
  localparam int CNT_W = $clog2(DEPTH + 1);

  res_t             slot_r   [DEPTH];
  res_t             slot_nxt [DEPTH];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] base;
  logic [1:0]       push_n;
  logic             pop;

  assign pop    = out_valid && out_ready;
  assign push_n = in_fire ? core_out.nres : 2'd0;
  assign base   = cnt_r - CNT_W'(pop);

  always_comb begin
    for (int i = 0; i < DEPTH - 1; i++) begin
      slot_nxt[i] = pop ? slot_r[i + 1] : slot_r[i];
    end
    slot_nxt[DEPTH - 1] = slot_r[DEPTH - 1];
    for (int i = 0; i < DEPTH; i++) begin
      if (push_n != 2'd0 && CNT_W'(i) == base) slot_nxt[i] = core_out.res0;
      if (push_n == 2'd2 && CNT_W'(i) == CNT_W'(base + 1'b1)) slot_nxt[i] = core_out.res1;
    end
    cnt_nxt = base + CNT_W'(push_n);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      slot_r[i] <= slot_nxt[i];
    end
  end

  assign space_ok  = cnt_r <= CNT_W'(DEPTH - 2);
  assign out_valid = cnt_r != '0;
  assign out_res   = slot_r[0];

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, base} + {1'b0, CNT_W'(push_n)} <= (CNT_W + 1)'(DEPTH))
    else $error("output queue overflow");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    pop && push_n == 2'd0 |=> cnt_r == $past(cnt_r) - 1'b1)
    else $error("queue count lost track on pop");

endmodule

>>> design/c_escape_decoder_top.sv
// C string escape decoder. One raw string byte enters per transfer on the
// in_ side (in_tlast marks the final byte of a string) and decoded bytes
// leave on the out_ side, each with the running decoded length of its
// string (saturating at 65535) and out_tlast on the final byte. Escapes
// \n \t \a \b \f \r \v \\ \" decode to one byte; \x takes two hex digits
// and a backslash-digit form takes the leading digit plus two more (base 8,
// any hex digit counts, non-digits count as zero), both modulo 256. An
// unknown escape yields the backslash and then the character. A string
// that ends inside an escape flushes it with missing digits as zero, and a
// trailing lone backslash comes out as itself. Throughput is one input
// transfer per clock while the output queue has room; an unknown escape
// produces two output transfers and holds in_tready low while the
// three-entry output queue drains. Decoded bytes are registered in the
// output queue before they leave. The input decode runs in a single pass
// of logic between the escape-state registers and the output queue.
module c_escape_decoder_top #(
  parameter int COUNT_BITS = 16   // width of the internal decoded-byte counter
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] in_char
  input  logic        in_tlast,    // in_last
  // decoded stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [7:0] out_byte, [23:8] out_length
  output logic        out_tlast    // out_last
);
  import c_esc_pkg::*;

  logic      in_fire;
  logic      space_ok;
  core_out_t core_out;
  res_t      out_res;

  // accept only while the queue can take two results
  assign in_tready = space_ok;
  assign in_fire   = in_tvalid && in_tready;

  c_esc_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_char  (in_tdata),
    .in_last  (in_tlast),
    .core_out (core_out)
  );

  c_esc_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .core_out  (core_out),
    .space_ok  (space_ok),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {out_res.length, out_res.data};
  assign out_tlast = out_res.last;

endmodule
